// ===== design/wwlf_pkg.sv =====
// Shared types and constants for the word wrap line folder.
package wwlf_pkg;

   localparam int CHAR_W  = 8;
   localparam int WIDTH_W = 6;

   localparam logic [CHAR_W-1:0]  SPACE_CODE  = 8'd32;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd63;

   // Request operation codes.
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Read address source for the line store.
   typedef enum logic {
      RD_IDX,
      RD_POS
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       cap_ch;
      logic       append_req;
      logic       append_held;
      logic       search_init;
      logic       pos_dec;
      logic       set_end_fill;
      logic       set_end_pos;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_from_pos;
      logic       dst_clr;
      logic       shift_wr;
      logic       set_fill_dst;
      logic       clear_fill;
      logic       load_char;
      logic       load_nl;
      rd_sel_type rd_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic fill_le1;
      logic rd_is_space;
      logic pos_is1;
      logic idx_eq_end;
      logic idx_eq_fill;
      logic ch_space;
      logic out_free;
   } sts_type;

endpackage

// ===== design/wwlf_req_if.sv =====
// Request channel: one character or newline request per item.
interface wwlf_req_if
   import wwlf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, output op, output char_in, input ready);
   modport sink   (input valid, input op, input char_in, output ready);
endinterface

// ===== design/wwlf_rsp_if.sv =====
// Response channel: one emitted character or line break per item.
interface wwlf_rsp_if
   import wwlf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              is_newline;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, output is_newline, output char_out, output last,
                   input ready);
   modport sink   (input valid, input is_newline, input char_out, input last,
                   output ready);
endinterface

// ===== design/word_wrap_line_folder.sv =====
// Top level of the greedy word wrap line folder.
//
//   Channel    Direction   Carries
//   req_chan   in          op, char_in (one character or newline request)
//   rsp_chan   out         is_newline, char_out, last (one emitted item)
//   csr_*      in          line_width write, no read-back
//
// A character that fits in the line is appended as it is taken. A newline request
// emits each stored entry and then a line break, and a fold searches back for a
// space, emits, then shifts the rest down; every step waits on the
// registered read of the line store. Reset clears the fill count and
// sets the width to 63; the store itself is not cleared. A stalled output holds
// the sequencer, while a result waiting in the output register does not block
// the next request item from being taken.
module word_wrap_line_folder
   import wwlf_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [WIDTH_W-1:0] csr_wdata,
   wwlf_req_if.sink           req_chan,
   wwlf_rsp_if.source         rsp_chan
);

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_chan.ready = req_ready;

   // Sequencer.
   wwlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Store, counters and output register.
   wwlf_dpath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_char  (req_chan.char_in),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== design/wwlf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module wwlf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/wwlf_dpath.sv =====
// Datapath: line store, fill count, pointers, width register and output register.
module wwlf_dpath
   import wwlf_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [WIDTH_W-1:0] csr_wdata,
   input  logic [CHAR_W-1:0]  req_char,
   input  cmd_type            cmd,
   output sts_type            sts,
   wwlf_rsp_if.source         rsp_chan
);

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int EW = (CW > WIDTH_W) ? CW : WIDTH_W;

   logic [WIDTH_W-1:0] width_ff;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      end_ff, end_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      dst_ff, dst_in;
   logic [CHAR_W-1:0]  ch_ff, ch_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_nl_ff, out_nl_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [CHAR_W-1:0]  ram_wdata, ram_rdata;
   logic [EW-1:0]      width_ext, width_eff, fill_ext;

   // Line store.
   wwlf_ram #(
      .DATA_W (CHAR_W),
      .DEPTH  (LINE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Store port selection.
   always_comb begin
      ram_we    = cmd.append_req | cmd.append_held | cmd.shift_wr;
      ram_waddr = cmd.shift_wr ? dst_ff[AW-1:0] : fill_ff[AW-1:0];
      if (cmd.append_req) begin
         ram_wdata = req_char;
      end else if (cmd.append_held) begin
         ram_wdata = ch_ff;
      end else begin
         ram_wdata = ram_rdata;
      end
      ram_raddr = (cmd.rd_sel == RD_POS) ? pos_ff[AW-1:0] : idx_ff[AW-1:0];
   end

   // Effective line width: zero acts as one, capped at the store depth.
   always_comb begin
      width_ext = EW'(width_ff);
      fill_ext  = EW'(fill_ff);
      if (width_ff == '0) begin
         width_eff = EW'(1);
      end else if (width_ext > EW'(LINE_DEPTH)) begin
         width_eff = EW'(LINE_DEPTH);
      end else begin
         width_eff = width_ext;
      end
   end

   // Next values of counters and pointers.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.append_req || cmd.append_held) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.set_fill_dst) begin
         fill_in = dst_ff;
      end

      pos_in = pos_ff;
      if (cmd.search_init) begin
         pos_in = fill_ff - CW'(1);
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - CW'(1);
      end

      end_in = end_ff;
      if (cmd.set_end_fill) begin
         end_in = fill_ff;
      end else if (cmd.set_end_pos) begin
         end_in = pos_ff;
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_from_pos) begin
         idx_in = pos_ff + CW'(1);
      end else if (cmd.idx_inc || cmd.shift_wr) begin
         idx_in = idx_ff + CW'(1);
      end

      dst_in = dst_ff;
      if (cmd.dst_clr) begin
         dst_in = '0;
      end else if (cmd.shift_wr) begin
         dst_in = dst_ff + CW'(1);
      end

      ch_in = cmd.cap_ch ? req_char : ch_ff;
   end

   // Output register: loads when empty or when its item is being taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_nl_in    = out_nl_ff;
      out_char_in  = out_char_ff;
      if (cmd.load_char) begin
         out_valid_in = 1'b1;
         out_nl_in    = 1'b0;
         out_char_in  = ram_rdata;
      end else if (cmd.load_nl) begin
         out_valid_in = 1'b1;
         out_nl_in    = 1'b1;
         out_char_in  = '0;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            width_ff <= csr_wdata;
         end
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      dst_ff      <= dst_in;
      ch_ff       <= ch_in;
      out_nl_ff   <= out_nl_in;
      out_char_ff <= out_char_in;
   end

   // Status to the controller.
   always_comb begin
      sts.full        = (fill_ext >= width_eff);
      sts.fill_le1    = (fill_ff <= CW'(1));
      sts.rd_is_space = (ram_rdata == SPACE_CODE);
      sts.pos_is1     = (pos_ff == CW'(1));
      sts.idx_eq_end  = (idx_ff == end_ff);
      sts.idx_eq_fill = (idx_ff == fill_ff);
      sts.ch_space    = (ch_ff == SPACE_CODE);
      sts.out_free    = !out_valid_ff || rsp_chan.ready;
   end

   // A line break always closes the run of one request.
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.is_newline = out_nl_ff;
   assign rsp_chan.char_out   = out_char_ff;
   assign rsp_chan.last       = out_nl_ff;

endmodule

// ===== design/wwlf_ctrl.sv =====
// Controller: sequences append, search, emit and shift for each request item.
module wwlf_ctrl
   import wwlf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_op,
   input  sts_type sts,
   output logic    req_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_EMIT_RD,
      S_EMIT_WAIT,
      S_NL,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_APPEND
   } state_type;

   typedef enum logic [1:0] {
      M_FLUSH,
      M_DUMP,
      M_FOLD
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      cmd        = '0;
      cmd.rd_sel = RD_IDX;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.cap_ch = 1'b1;
               if (req_op == OP_FLUSH) begin
                  mode_in          = M_FLUSH;
                  cmd.set_end_fill = 1'b1;
                  cmd.idx_clr      = 1'b1;
                  state_in         = S_EMIT_RD;
               end else if (!sts.full) begin
                  cmd.append_req = 1'b1;
               end else if (sts.fill_le1) begin
                  mode_in          = M_DUMP;
                  cmd.set_end_fill = 1'b1;
                  cmd.idx_clr      = 1'b1;
                  state_in         = S_EMIT_RD;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            cmd.rd_sel = RD_POS;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd.rd_sel = RD_POS;
            if (sts.rd_is_space) begin
               mode_in         = M_FOLD;
               cmd.set_end_pos = 1'b1;
               cmd.idx_clr     = 1'b1;
               state_in        = S_EMIT_RD;
            end else if (sts.pos_is1) begin
               mode_in          = M_DUMP;
               cmd.set_end_fill = 1'b1;
               cmd.idx_clr      = 1'b1;
               state_in         = S_EMIT_RD;
            end else begin
               cmd.pos_dec = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = sts.idx_eq_end ? S_NL : S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (sts.out_free) begin
               cmd.load_char = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_EMIT_RD;
            end
         end
         S_NL: begin
            if (sts.out_free) begin
               cmd.load_nl = 1'b1;
               case (mode_ff)
                  M_FOLD: begin
                     cmd.idx_from_pos = 1'b1;
                     cmd.dst_clr      = 1'b1;
                     state_in         = S_SHIFT_RD;
                  end
                  M_DUMP: begin
                     cmd.clear_fill = 1'b1;
                     state_in       = S_APPEND;
                  end
                  default: begin
                     cmd.clear_fill = 1'b1;
                     state_in       = S_IDLE;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            if (sts.idx_eq_fill) begin
               cmd.set_fill_dst = 1'b1;
               state_in         = S_APPEND;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_APPEND: begin
            // A space that follows a dump without a fold point is dropped.
            if (mode_ff == M_FOLD || !sts.ch_space) begin
               cmd.append_held = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and mode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= M_FLUSH;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule
